### rtl/blisd_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list package
// Request and response types, opcode and status codes, and the default depth
// for the bounded list with insert, search and delete.
// ----------------------------------------------------------------------------
package blisd_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned POSITION_W    = 6;
    localparam int unsigned LENGTH_W      = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DELETE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOTFOUND = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [VALUE_W-1:0]  value;
    } request_t;

    typedef struct packed {
        status_t                 status;
        logic [POSITION_W-1:0]   position;
        logic [LENGTH_W-1:0]     length;
    } result_t;

endpackage

### rtl/bounded_list_insert_search_delete.sv
// ----------------------------------------------------------------------------
// Bounded list with insert at head, clear, search and delete
// Keeps up to DEPTH signed 32-bit values in one synchronous memory, newest at
// the head, and answers each request with a status, a position and a length.
//
// Requests enter on req_valid/req_ready and carry an opcode and a value. Each
// request gives exactly one response on rsp_valid/rsp_ready. A new request is
// taken only while the block is idle; a finished response may still wait in
// the output register while the next request is taken.
// Insert, clear, and search or delete on an empty list go from the idle state
// straight to the done state, which loads the response register. Search and
// delete walk the memory from the head one entry per cycle through its single
// read port. A delete then moves every entry between the match and the head
// down by one slot, one entry per cycle through the same read and write ports.
// Reset empties the list; memory contents are not cleared and no clearing
// pass is needed. When the receiver stalls, the response holds in the output
// register and the block waits before it finishes the next request.
// ----------------------------------------------------------------------------
module bounded_list_insert_search_delete
    import blisd_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  request_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output result_t  rsp_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    logic [VALUE_W-1:0] mem [DEPTH];

    state_t             state_reg,     state_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [VALUE_W-1:0] key_reg,       key_next;
    logic               is_del_reg,    is_del_next;
    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    logic               issue_reg,     issue_next;
    logic               rd_valid_reg,  rd_valid_next;
    logic [AW-1:0]      rd_addr_reg,   rd_addr_next;
    logic [VALUE_W-1:0] rd_data_reg;
    result_t            res_reg,       res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    result_t            rsp_data_reg,  rsp_data_next;

    logic               mem_we;
    logic [AW-1:0]      mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic [CW-1:0]      count_dec;
    logic [CW-1:0]      pos_full;
    logic               rd_is_head;
    logic               scan_is_head;

    assign count_dec    = count_reg - CW'(1);
    assign pos_full     = count_dec - CW'(rd_addr_reg);
    assign rd_is_head   = (CW'(rd_addr_reg) == count_dec);
    assign scan_is_head = (CW'(scan_addr_reg) == count_dec);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        is_del_next    = is_del_reg;
        scan_addr_next = scan_addr_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        rd_addr_next   = scan_addr_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_wr_addr    = count_reg[AW-1:0];
        mem_wr_data    = req_data.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next    = req_data.value;
                    is_del_next = (req_data.opcode == OP_DELETE);
                    state_next  = ST_DONE;
                    unique case (req_data.opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_next = '{STATUS_FULL, '0, LENGTH_W'(count_reg)};
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                res_next   = '{STATUS_OK, '0,
                                               LENGTH_W'(count_reg + CW'(1))};
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            res_next   = '{STATUS_OK, '0, '0};
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = '{STATUS_EMPTY, '0, '0};
                            end
                            else
                            begin
                                scan_addr_next = count_dec[AW-1:0];
                                issue_next     = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_valid_next = 1'b1;
                    if (scan_addr_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg - AW'(1);
                    end
                end
                if (rd_valid_reg)
                begin
                    if (rd_data_reg == key_reg)
                    begin
                        rd_valid_next = 1'b0;
                        if (!is_del_reg)
                        begin
                            res_next   = '{STATUS_OK, POSITION_W'(pos_full),
                                           LENGTH_W'(count_reg)};
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            res_next = '{STATUS_OK, POSITION_W'(pos_full),
                                         LENGTH_W'(count_dec)};
                            if (rd_is_head)
                            begin
                                count_next = count_dec;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                scan_addr_next = rd_addr_reg + AW'(1);
                                issue_next     = 1'b1;
                                state_next     = ST_SHIFT;
                            end
                        end
                    end
                    else if (rd_addr_reg == '0)
                    begin
                        rd_valid_next = 1'b0;
                        res_next      = '{STATUS_NOTFOUND, '0, LENGTH_W'(count_reg)};
                        state_next    = ST_DONE;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (issue_reg)
                begin
                    rd_valid_next = 1'b1;
                    if (scan_is_head)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + AW'(1);
                    end
                end
                if (rd_valid_reg)
                begin
                    mem_we      = 1'b1;
                    mem_wr_addr = rd_addr_reg - AW'(1);
                    mem_wr_data = rd_data_reg;
                    if (rd_is_head)
                    begin
                        rd_valid_next = 1'b0;
                        count_next    = count_dec;
                        state_next    = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        is_del_reg    <= is_del_next;
        scan_addr_reg <= scan_addr_next;
        rd_addr_reg   <= rd_addr_next;
        res_reg       <= res_next;
        rsp_data_reg  <= rsp_data_next;
    end

endmodule
